FILE: sv/gdas_pkg.sv
package gdas_pkg;

   localparam int DAY_W          = 5;
   localparam int MONTH_W        = 4;
   localparam int YEAR_W         = 14;
   localparam int COUNT_PORT_W   = 16;
   localparam int STATUS_W       = 2;

   localparam int MIN_YEAR_DEF   = 1900;
   localparam int MAX_YEAR_DEF   = 9999;
   localparam int COUNT_BITS_DEF = 16;

   // year / 100 by reciprocal: q = (y * 5243) >> 19, exact for 14-bit years
   localparam int RECIP_100      = 5243;
   localparam int RECIP_W        = 13;
   localparam int RECIP_SHIFT    = 19;
   localparam int CENT_W         = 8;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVER     = 2'd3;

   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] APRIL    = 4'd4;
   localparam logic [MONTH_W-1:0] JUNE     = 4'd6;
   localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
   localparam logic [MONTH_W-1:0] NOVEMBER = 4'd11;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   // microprogram addresses
   localparam pc_type P_START = 4'd0;
   localparam pc_type P_CHECK = 4'd1;
   localparam pc_type P_DISP  = 4'd2;
   localparam pc_type P_ALOOP = 4'd3;
   localparam pc_type P_AEND  = 4'd4;
   localparam pc_type P_OK    = 4'd5;
   localparam pc_type P_SLOOP = 4'd6;
   localparam pc_type P_SEND  = 4'd7;
   localparam pc_type P_SFIN  = 4'd8;
   localparam pc_type P_BAD   = 4'd9;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ADDC,
      OP_ADV,
      OP_RET,
      OP_OUT_OK,
      OP_OUT_SUB,
      OP_OUT_BAD,
      OP_OUT_UNDER,
      OP_OUT_OVER
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_BAD,
      C_SUB,
      C_ADD_STOP,
      C_FIT,
      C_SUB_STOP,
      C_LT
   } cond_type;

   // cond true: jump to jmp, op skipped; else op runs and pc goes to nxt, unless an output op is held
   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   jmp;
      pc_type   nxt;
   } uword_type;

   function automatic uword_type ucode(input pc_type addr);
      uword_type w;
      w = '{op: OP_NOP, cond: C_NEVER, jmp: P_START, nxt: P_START};
      case (addr)
         P_START: w = '{op: OP_NOP,       cond: C_NEVER,    jmp: P_START, nxt: P_CHECK};
         P_CHECK: w = '{op: OP_NOP,       cond: C_BAD,      jmp: P_BAD,   nxt: P_DISP};
         P_DISP:  w = '{op: OP_ADDC,      cond: C_SUB,      jmp: P_SLOOP, nxt: P_ALOOP};
         P_ALOOP: w = '{op: OP_ADV,       cond: C_ADD_STOP, jmp: P_AEND,  nxt: P_ALOOP};
         P_AEND:  w = '{op: OP_OUT_OVER,  cond: C_FIT,      jmp: P_OK,    nxt: P_START};
         P_OK:    w = '{op: OP_OUT_OK,    cond: C_NEVER,    jmp: P_START, nxt: P_START};
         P_SLOOP: w = '{op: OP_RET,       cond: C_SUB_STOP, jmp: P_SEND,  nxt: P_SLOOP};
         P_SEND:  w = '{op: OP_OUT_UNDER, cond: C_LT,       jmp: P_SFIN,  nxt: P_START};
         P_SFIN:  w = '{op: OP_OUT_SUB,   cond: C_NEVER,    jmp: P_START, nxt: P_START};
         P_BAD:   w = '{op: OP_OUT_BAD,   cond: C_NEVER,    jmp: P_START, nxt: P_START};
         default: w = '{op: OP_NOP,       cond: C_NEVER,    jmp: P_START, nxt: P_START};
      endcase
      return w;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      len = 5'd31;
      case (m)
         FEBRUARY:  len = leap ? 5'd29 : 5'd28;
         APRIL:     len = 5'd30;
         JUNE:      len = 5'd30;
         SEPTEMBER: len = 5'd30;
         NOVEMBER:  len = 5'd30;
         default:   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: sv/gregorian_date_add_sub_days.sv
// flow: the program checks the date first and gives an invalid date a bad-date result;
// otherwise it walks the date over month boundaries one at a time until the result
// fits, saturates at the top year or falls under the first year
// throughput: one item at a time; the next item is accepted the cycle after the
// result is loaded into the output register, even while that result still waits
// reset: synchronous, active high; clears the sequencer and the output valid
module gregorian_date_add_sub_days #(
   parameter int MIN_YEAR   = gdas_pkg::MIN_YEAR_DEF,
   parameter int MAX_YEAR   = gdas_pkg::MAX_YEAR_DEF,
   parameter int COUNT_BITS = gdas_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [gdas_pkg::DAY_W-1:0]         req_day,
   input  logic [gdas_pkg::MONTH_W-1:0]       req_month,
   input  logic [gdas_pkg::YEAR_W-1:0]        req_year,
   input  logic [gdas_pkg::COUNT_PORT_W-1:0]  req_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [gdas_pkg::DAY_W-1:0]         rsp_res_day,
   output logic [gdas_pkg::MONTH_W-1:0]       rsp_res_month,
   output logic [gdas_pkg::YEAR_W-1:0]        rsp_res_year,
   output logic [gdas_pkg::STATUS_W-1:0]      rsp_status
);
   import gdas_pkg::*;

   // count bits actually used, and a day register wide enough for day + count
   localparam int CNT_W = (COUNT_BITS < COUNT_PORT_W) ? COUNT_BITS : COUNT_PORT_W;
   localparam int DW    = ((CNT_W > DAY_W) ? CNT_W : DAY_W) + 1;
   localparam logic [YEAR_W-1:0] MIN_Y = YEAR_W'(MIN_YEAR);
   localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);
   localparam int PROD_W = YEAR_W + RECIP_W;

   // control
   logic                busy_ff, busy_in;
   pc_type              pc_ff, pc_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath
   logic                cmd_ff, cmd_in;
   logic [DW-1:0]       d_ff, d_in;
   logic [MONTH_W-1:0]  m_ff, m_in;
   logic [YEAR_W-1:0]   y_ff, y_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CENT_W-1:0]   q_ff, q_in;

   // output register
   logic [DAY_W-1:0]    res_day_ff, res_day_in;
   logic [MONTH_W-1:0]  res_month_ff, res_month_in;
   logic [YEAR_W-1:0]   res_year_ff, res_year_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   uword_type           uw;
   logic [PROD_W-1:0]   prod;
   logic [YEAR_W:0]     cent_x100;
   logic                leap;
   logic [DAY_W-1:0]    mlen, mlen_prev;
   logic [MONTH_W-1:0]  m_prev;
   logic                fit, cnt_lt, bad, taken, is_out, out_free, hold;
   logic                at_dec_top, at_jan_bottom;
   logic [DW-1:0]       d_minus_cnt;

   assign req_ready     = !busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_day   = res_day_ff;
   assign rsp_res_month = res_month_ff;
   assign rsp_res_year  = res_year_ff;
   assign rsp_status    = status_ff;

   always_comb begin
      // century number of the current year, registered below; valid in the
      // cycle after the year changes, which the program always allows for
      prod      = PROD_W'(y_ff) * PROD_W'(RECIP_100);
      q_in      = prod[RECIP_SHIFT +: CENT_W];
      cent_x100 = ((YEAR_W+1)'({q_ff, 6'b0}) + (YEAR_W+1)'({q_ff, 5'b0}))
                  + (YEAR_W+1)'({q_ff, 2'b0});
      // 400/100/4 rule
      if (cent_x100 == {1'b0, y_ff}) begin
         leap = (q_ff[1:0] == 2'b00);
      end else begin
         leap = (y_ff[1:0] == 2'b00);
      end

      mlen      = month_len(m_ff, leap);
      m_prev    = (m_ff == JANUARY) ? DECEMBER : m_ff - 4'd1;
      // a year wrap only ever lands on december, where leap does not matter
      mlen_prev = month_len(m_prev, leap);

      fit           = (d_ff <= DW'(mlen));
      cnt_lt        = (DW'(cnt_ff) < d_ff);
      at_dec_top    = (m_ff == DECEMBER) && (y_ff >= MAX_Y);
      at_jan_bottom = (m_ff == JANUARY) && (y_ff <= MIN_Y);
      bad           = (y_ff < MIN_Y) || (y_ff > MAX_Y) || (m_ff < JANUARY) ||
                      (m_ff > DECEMBER) || (d_ff == '0) || (d_ff > DW'(mlen));
      d_minus_cnt   = d_ff - DW'(cnt_ff);

      uw = ucode(pc_ff);
      case (uw.cond)
         C_NEVER:    taken = 1'b0;
         C_BAD:      taken = bad;
         C_SUB:      taken = cmd_ff;
         C_ADD_STOP: taken = fit || at_dec_top;
         C_FIT:      taken = fit;
         C_SUB_STOP: taken = cnt_lt || at_jan_bottom;
         C_LT:       taken = cnt_lt;
         default:    taken = 1'b0;
      endcase

      is_out   = (uw.op == OP_OUT_OK) || (uw.op == OP_OUT_SUB) || (uw.op == OP_OUT_BAD) ||
                 (uw.op == OP_OUT_UNDER) || (uw.op == OP_OUT_OVER);
      out_free = !rsp_valid_ff || rsp_ready;
      // a finished result waits here while the output register is still full
      hold     = busy_ff && is_out && !taken && !out_free;

      busy_in      = busy_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd_in       = cmd_ff;
      d_in         = d_ff;
      m_in         = m_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      res_day_in   = res_day_ff;
      res_month_in = res_month_ff;
      res_year_in  = res_year_ff;
      status_in    = status_ff;

      if (busy_ff) begin
         if (taken) begin
            pc_in = uw.jmp;
         end else if (!hold) begin
            pc_in = uw.nxt;
            case (uw.op)
               OP_NOP: begin
               end
               OP_ADDC: begin
                  d_in = d_ff + DW'(cnt_ff);
               end
               OP_ADV: begin
                  // step forward over the whole current month
                  d_in = d_ff - DW'(mlen);
                  if (m_ff == DECEMBER) begin
                     m_in = JANUARY;
                     y_in = y_ff + 14'd1;
                  end else begin
                     m_in = m_ff + 4'd1;
                  end
               end
               OP_RET: begin
                  // step back to the last day of the previous month
                  cnt_in = cnt_ff - CNT_W'(d_ff);
                  m_in   = m_prev;
                  if (m_ff == JANUARY) begin
                     y_in = y_ff - 14'd1;
                  end
                  d_in = DW'(mlen_prev);
               end
               OP_OUT_OK: begin
                  res_day_in   = d_ff[DAY_W-1:0];
                  res_month_in = m_ff;
                  res_year_in  = y_ff;
                  status_in    = ST_OK;
               end
               OP_OUT_SUB: begin
                  res_day_in   = d_minus_cnt[DAY_W-1:0];
                  res_month_in = m_ff;
                  res_year_in  = y_ff;
                  status_in    = ST_OK;
               end
               OP_OUT_BAD: begin
                  res_day_in   = 5'd1;
                  res_month_in = JANUARY;
                  res_year_in  = MIN_Y;
                  status_in    = ST_BAD_DATE;
               end
               OP_OUT_UNDER: begin
                  res_day_in   = 5'd1;
                  res_month_in = JANUARY;
                  res_year_in  = MIN_Y;
                  status_in    = ST_UNDER;
               end
               OP_OUT_OVER: begin
                  res_day_in   = 5'd31;
                  res_month_in = DECEMBER;
                  res_year_in  = MAX_Y;
                  status_in    = ST_OVER;
               end
               default: begin
               end
            endcase
            if (is_out) begin
               rsp_valid_in = 1'b1;
               busy_in      = 1'b0;
            end
         end
      end else if (req_valid) begin
         // load the item and start the program
         busy_in = 1'b1;
         pc_in   = P_START;
         cmd_in  = req_command;
         d_in    = DW'(req_day);
         m_in    = req_month;
         y_in    = req_year;
         cnt_in  = req_count[CNT_W-1:0];
      end
   end

   // sequencer and handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= P_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and output payload
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      d_ff         <= d_in;
      m_ff         <= m_in;
      y_ff         <= y_in;
      cnt_ff       <= cnt_in;
      q_ff         <= q_in;
      res_day_ff   <= res_day_in;
      res_month_ff <= res_month_in;
      res_year_ff  <= res_year_in;
      status_ff    <= status_in;
   end

   // an accepted item always starts the program at its first step
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (busy_ff && pc_ff == P_START))
      else $error("accepted item did not start the sequencer");

   // a new result only appears when the sequencer was running
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("result appeared without a running item");

   // the backward walk always keeps a day within one month
   a_sub_day: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (pc_ff == P_SLOOP || pc_ff == P_SEND || pc_ff == P_SFIN))
      |-> (d_ff <= DW'(31)))
      else $error("day out of range in backward walk");

   // a saturated result is the last day of the top year
   a_over: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_OVER)
      |-> (res_day_ff == 5'd31 && res_month_ff == DECEMBER && res_year_ff == MAX_Y))
      else $error("overflow result not saturated");

   // a good result carries a real month and a nonzero day
   a_ok_month: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_OK)
      |-> (res_month_ff >= JANUARY && res_month_ff <= DECEMBER && res_day_ff != '0))
      else $error("ok result with bad month or day");

endmodule
